### rtl/rbd2_pkg.sv
// Shared types and constants for the RGBA 2x2 box downsampler.
package rbd2_pkg;

    localparam int unsigned NUM_CH    = 4;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned PAIR_W    = PIX_W + 1;
    localparam int unsigned SUM_W     = PIX_W + 2;
    localparam int unsigned SRC_W_W   = 13;
    localparam int unsigned SRC_H_W   = 16;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [NUM_CH-1:0][PIX_W-1:0]  pix_vec_t;
    typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_vec_t;

    typedef enum logic [0:0] {
        CFG_SRC_WIDTH  = 1'b0,
        CFG_SRC_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic use_store;
        logic row_end;
        logic frame_end;
    } blk_tag_t;

endpackage

### rtl/rbd2_line_mem.sv
// Line store of horizontal pair sums, one write port and one registered read port.
module rbd2_line_mem #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic                rd_en,
    input  logic [AW-1:0]       addr,
    input  rbd2_pkg::pair_vec_t wr_data,
    output rbd2_pkg::pair_vec_t rd_data
);

    rbd2_pkg::pair_vec_t mem [0:DEPTH-1];
    rbd2_pkg::pair_vec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rbd2_pair_gen.sv
// Source position tracking, horizontal pairing and line store access.
module rbd2_pair_gen #(
    parameter int unsigned MAX_WIDTH = 4096,
    parameter int unsigned EW        = 13,
    parameter int unsigned AW        = 11
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [EW-1:0]                  eff_w,
    input  logic [EW-1:0]                  dw,
    input  logic                           w_is_one,
    input  logic [rbd2_pkg::SRC_H_W-1:0]   eff_h,
    input  logic [rbd2_pkg::SRC_H_W-1:0]   dh,
    input  logic                           h_is_one,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_start_of_frame,
    input  rbd2_pkg::pix_vec_t             s_pix,
    input  logic                           a_adv,
    output logic                           a_valid,
    output rbd2_pkg::pair_vec_t            a_pair,
    output rbd2_pkg::blk_tag_t             a_tag,
    output logic                           mem_wr_en,
    output logic                           mem_rd_en,
    output logic [AW-1:0]                  mem_addr,
    output rbd2_pkg::pair_vec_t            mem_wr_data
);

    localparam int unsigned CLW = $clog2(MAX_WIDTH);
    localparam int unsigned HW  = rbd2_pkg::SRC_H_W;

    logic [CLW-1:0]         col_reg, col_next, col_pos;
    logic [HW-1:0]          row_reg, row_next, row_pos;
    rbd2_pkg::pix_vec_t     held_reg;
    logic                   a_valid_reg;
    rbd2_pkg::pair_vec_t    a_pair_reg;
    rbd2_pkg::blk_tag_t     a_tag_reg;

    logic                   accept, active, have_pair, row_ok, wrap, emit;
    logic [AW-1:0]          x;
    logic [HW-1:0]          y;
    rbd2_pkg::pair_vec_t    pair;
    rbd2_pkg::blk_tag_t     tag;

    assign accept  = s_valid && s_ready;
    assign s_ready = !a_valid_reg || a_adv;
    assign col_pos = s_start_of_frame ? '0 : col_reg;
    assign row_pos = s_start_of_frame ? '0 : row_reg;
    assign active  = row_pos < eff_h;
    assign row_ok  = (HW + 1)'(row_pos) < ((HW + 1)'(dh) << 1);
    assign wrap    = ((EW + 1)'(col_pos) + (EW + 1)'(1)) >= (EW + 1)'(eff_w);

    always_comb begin
        pair      = '0;
        have_pair = 1'b0;
        x         = AW'(col_pos >> 1);
        if (w_is_one) begin
            for (int c = 0; c < rbd2_pkg::NUM_CH; c++) begin
                pair[c] = {s_pix[c], 1'b0};
            end
            x         = '0;
            have_pair = 1'b1;
        end else if (col_pos[0]) begin
            for (int c = 0; c < rbd2_pkg::NUM_CH; c++) begin
                pair[c] = rbd2_pkg::PAIR_W'(held_reg[c]) + rbd2_pkg::PAIR_W'(s_pix[c]);
            end
            have_pair = (EW + 1)'(col_pos) < ((EW + 1)'(dw) << 1);
        end
    end

    always_comb begin
        y             = h_is_one ? '0 : (row_pos >> 1);
        tag.use_store = !h_is_one;
        tag.row_end   = EW'(x) == (dw - EW'(1));
        tag.frame_end = tag.row_end && (y == (dh - HW'(1)));
    end

    assign emit        = accept && active && have_pair && (h_is_one || (row_ok && row_pos[0]));
    assign mem_wr_en   = accept && active && have_pair && !h_is_one && row_ok && !row_pos[0];
    assign mem_rd_en   = emit && !h_is_one;
    assign mem_addr    = x;
    assign mem_wr_data = pair;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && active) begin
            if (wrap) begin
                col_next = '0;
                row_next = row_pos + HW'(1);
            end else begin
                col_next = col_pos + CLW'(1);
                row_next = row_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            held_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept && active && !w_is_one && !col_pos[0]) begin
                held_reg <= s_pix;
            end
            if (s_ready) begin
                a_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            a_pair_reg <= pair;
            a_tag_reg  <= tag;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_pair  = a_pair_reg;
    assign a_tag   = a_tag_reg;

endmodule

### rtl/rbd2_avg_out.sv
// Vertical sum, divide by four and output register.
module rbd2_avg_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                a_valid,
    input  rbd2_pkg::pair_vec_t a_pair,
    input  rbd2_pkg::blk_tag_t  a_tag,
    input  rbd2_pkg::pair_vec_t store_data,
    output logic                a_adv,
    output logic                m_valid,
    input  logic                m_ready,
    output rbd2_pkg::pix_vec_t  m_pix,
    output logic                m_row_end,
    output logic                m_frame_end
);

    logic                                          m_valid_reg;
    rbd2_pkg::pix_vec_t                            pix_reg;
    logic                                          row_end_reg, frame_end_reg;
    logic [rbd2_pkg::NUM_CH-1:0][rbd2_pkg::SUM_W-1:0] sum;

    assign a_adv = !m_valid_reg || m_ready;

    always_comb begin
        for (int c = 0; c < rbd2_pkg::NUM_CH; c++) begin
            if (a_tag.use_store) begin
                sum[c] = rbd2_pkg::SUM_W'(store_data[c]) + rbd2_pkg::SUM_W'(a_pair[c]);
            end else begin
                sum[c] = {a_pair[c], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_adv) begin
            m_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && a_valid) begin
            for (int c = 0; c < rbd2_pkg::NUM_CH; c++) begin
                pix_reg[c] <= sum[c][rbd2_pkg::SUM_W-1:2];
            end
            row_end_reg   <= a_tag.row_end;
            frame_end_reg <= a_tag.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pix       = pix_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

### rtl/rgba_box_downsample_2x2.sv
// Top level of the RGBA8 2x2 box-filter downsampler.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    start_of_frame, red, green, blue, alpha
//   m_        out        m_valid/m_ready    out_red..out_alpha, row_end, frame_end
//   cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// One source pixel per cycle while s_ready is high; a block result is registered with its
// line store read, then held in the output register until taken.
// Reset clears position, held pixel and valid flags; the line store is not cleared.
// A stalled output holds the pipeline stage behind it and drops s_ready only then.
module rgba_box_downsample_2x2 #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_index,
    input  logic [rbd2_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_of_frame,
    input  logic [7:0]                          s_red,
    input  logic [7:0]                          s_green,
    input  logic [7:0]                          s_blue,
    input  logic [7:0]                          s_alpha,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_red,
    output logic [7:0]                          m_out_green,
    output logic [7:0]                          m_out_blue,
    output logic [7:0]                          m_out_alpha,
    output logic                                m_row_end,
    output logic                                m_frame_end
);

    localparam int unsigned DEPTH = MAX_WIDTH / 2;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned EW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMPW  = (EW > rbd2_pkg::SRC_W_W) ? EW : rbd2_pkg::SRC_W_W;
    localparam int unsigned HW    = rbd2_pkg::SRC_H_W;

    logic [rbd2_pkg::SRC_W_W-1:0] src_width_reg;
    logic [HW-1:0]                src_height_reg;
    logic [CMPW-1:0]              w_ext;
    logic [EW-1:0]                eff_w, dw;
    logic [HW-1:0]                eff_h, dh;
    logic                         w_is_one, h_is_one;

    rbd2_pkg::pix_vec_t           s_pix, m_pix;
    logic                         a_valid, a_adv;
    rbd2_pkg::pair_vec_t          a_pair, mem_wr_data, mem_rd_data;
    rbd2_pkg::blk_tag_t           a_tag;
    logic                         mem_wr_en, mem_rd_en;
    logic [AW-1:0]                mem_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= rbd2_pkg::SRC_W_W'(1);
            src_height_reg <= HW'(1);
        end else if (cfg_wr_en) begin
            unique case (rbd2_pkg::cfg_idx_t'(cfg_wr_index))
                rbd2_pkg::CFG_SRC_WIDTH: begin
                    src_width_reg <= cfg_wr_data[rbd2_pkg::SRC_W_W-1:0];
                end
                rbd2_pkg::CFG_SRC_HEIGHT: begin
                    src_height_reg <= cfg_wr_data[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_ext = CMPW'(src_width_reg);
        if (w_ext == '0) begin
            eff_w = EW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(w_ext);
        end
        dw       = (eff_w > EW'(1)) ? (eff_w >> 1) : EW'(1);
        w_is_one = eff_w == EW'(1);
        eff_h    = (src_height_reg == '0) ? HW'(1) : src_height_reg;
        dh       = (eff_h > HW'(1)) ? (eff_h >> 1) : HW'(1);
        h_is_one = eff_h == HW'(1);
    end

    assign s_pix = {s_alpha, s_blue, s_green, s_red};

    rbd2_pair_gen #(
        .MAX_WIDTH (MAX_WIDTH),
        .EW        (EW),
        .AW        (AW)
    ) u_pair_gen (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .eff_w            (eff_w),
        .dw               (dw),
        .w_is_one         (w_is_one),
        .eff_h            (eff_h),
        .dh               (dh),
        .h_is_one         (h_is_one),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_of_frame (s_start_of_frame),
        .s_pix            (s_pix),
        .a_adv            (a_adv),
        .a_valid          (a_valid),
        .a_pair           (a_pair),
        .a_tag            (a_tag),
        .mem_wr_en        (mem_wr_en),
        .mem_rd_en        (mem_rd_en),
        .mem_addr         (mem_addr),
        .mem_wr_data      (mem_wr_data)
    );

    rbd2_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    rbd2_avg_out u_avg_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .a_valid     (a_valid),
        .a_pair      (a_pair),
        .a_tag       (a_tag),
        .store_data  (mem_rd_data),
        .a_adv       (a_adv),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pix       (m_pix),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

    assign m_out_red   = m_pix[0];
    assign m_out_green = m_pix[1];
    assign m_out_blue  = m_pix[2];
    assign m_out_alpha = m_pix[3];

endmodule

### test/box_downsample_checker.sv
// Scoreboard for the RGBA 2x2 box downsampler: predicts each output block and checks every beat.
module box_downsample_checker #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_index,
    input  logic [rbd2_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_start_of_frame,
    input  logic [7:0]                      s_red,
    input  logic [7:0]                      s_green,
    input  logic [7:0]                      s_blue,
    input  logic [7:0]                      s_alpha,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [7:0]                      m_out_red,
    input  logic [7:0]                      m_out_green,
    input  logic [7:0]                      m_out_blue,
    input  logic [7:0]                      m_out_alpha,
    input  logic                            m_row_end,
    input  logic                            m_frame_end,
    output int                              fail_count,
    output int                              pending,
    output int                              pixels_seen,
    output int                              blocks_seen
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    typedef struct packed {
        rbd2_pkg::pix_vec_t avg;
        logic               row_end;
        logic               frame_end;
    } block_t;

    logic [rbd2_pkg::SRC_W_W-1:0] src_width;
    logic [rbd2_pkg::SRC_H_W-1:0] src_height;
    rbd2_pkg::pair_vec_t          line_pairs [MAX_WIDTH/2];
    rbd2_pkg::pix_vec_t           held_left;
    logic [CW-1:0]                col_pos;
    logic [rbd2_pkg::SRC_H_W-1:0] row_pos;
    block_t                       blocks_due [$];
    block_t                       want;
    int                           errors = 0;
    int                           n_pix = 0;
    int                           n_blk = 0;

    function automatic void average_block(input logic sof, input rbd2_pkg::pix_vec_t px);
        int unsigned                                      w, h, dw, dh, col, row, x, y;
        int                                               c;
        rbd2_pkg::pair_vec_t                              pair;
        logic [rbd2_pkg::NUM_CH-1:0][rbd2_pkg::SUM_W-1:0] sum;
        logic                                             have_pair;
        block_t                                           blk;
        w = (src_width == 0) ? 1 : (src_width > MAX_WIDTH) ? MAX_WIDTH : src_width;
        h = (src_height == 0) ? 1 : src_height;
        dw = (w / 2 != 0) ? w / 2 : 1;
        dh = (h / 2 != 0) ? h / 2 : 1;
        have_pair = 1'b0;
        pair = '0;
        sum = '0;
        if (sof) begin
            col_pos = '0;
            row_pos = '0;
        end
        if (row_pos >= h) return;
        col = col_pos;
        row = row_pos;
        x = col >> 1;
        if (w == 1) begin
            for (c = 0; c < rbd2_pkg::NUM_CH; c++) pair[c] = {px[c], 1'b0};
            x = 0;
            have_pair = 1'b1;
        end else if (col % 2 == 1) begin
            if (col < 2 * dw) begin
                for (c = 0; c < rbd2_pkg::NUM_CH; c++)
                    pair[c] = {1'b0, held_left[c]} + {1'b0, px[c]};
                have_pair = 1'b1;
            end
        end else begin
            held_left = px;
        end
        if (col + 1 >= w) begin
            col_pos = '0;
            row_pos = rbd2_pkg::SRC_H_W'(row + 1);
        end else begin
            col_pos = CW'(col + 1);
        end
        if (!have_pair) return;
        if (h == 1) begin
            for (c = 0; c < rbd2_pkg::NUM_CH; c++) sum[c] = {pair[c], 1'b0};
            y = 0;
        end else if (row >= 2 * dh) begin
            return;
        end else if (row % 2 == 0) begin
            line_pairs[x] = pair;
            return;
        end else begin
            for (c = 0; c < rbd2_pkg::NUM_CH; c++)
                sum[c] = {1'b0, line_pairs[x][c]} + {1'b0, pair[c]};
            y = row / 2;
        end
        for (c = 0; c < rbd2_pkg::NUM_CH; c++) blk.avg[c] = sum[c][rbd2_pkg::SUM_W-1:2];
        blk.row_end = (x == dw - 1);
        blk.frame_end = (x == dw - 1) && (y == dh - 1);
        blocks_due.push_back(blk);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            src_width = rbd2_pkg::SRC_W_W'(1);
            src_height = rbd2_pkg::SRC_H_W'(1);
            held_left = '0;
            col_pos = '0;
            row_pos = '0;
            blocks_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == rbd2_pkg::CFG_SRC_WIDTH)
                    src_width = cfg_wr_data[rbd2_pkg::SRC_W_W-1:0];
                else
                    src_height = cfg_wr_data[rbd2_pkg::SRC_H_W-1:0];
            end
            if (s_valid && s_ready) begin
                n_pix++;
                average_block(s_start_of_frame, {s_alpha, s_blue, s_green, s_red});
            end
            if (m_valid && m_ready) begin
                if (blocks_due.size() == 0) begin
                    $error("output beat with no block due");
                    errors++;
                end else begin
                    want = blocks_due.pop_front();
                    n_blk++;
                    check_field("out_red", want.avg[0], m_out_red);
                    check_field("out_green", want.avg[1], m_out_green);
                    check_field("out_blue", want.avg[2], m_out_blue);
                    check_field("out_alpha", want.avg[3], m_out_alpha);
                    check_field("row_end", want.row_end, m_row_end);
                    check_field("frame_end", want.frame_end, m_frame_end);
                end
            end
        end
        fail_count <= errors;
        pending <= blocks_due.size();
        pixels_seen <= n_pix;
        blocks_seen <= n_blk;
    end

endmodule

### test/testbench.sv
// Top of the box downsampler regression: clock, reset, pixel stimulus, watchdog and verdict.
module testbench;

    localparam int unsigned MAX_WIDTH     = 4096;
    localparam int unsigned TARGET_PIXELS = 1850;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned FRAME_CAP     = 400;

    typedef enum logic [1:0] {
        RECV_OPEN,
        RECV_RANDOM,
        RECV_BURSTY
    } recv_mode_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic                            cfg_wr_index = 1'b0;
    logic [rbd2_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_start_of_frame = 1'b0;
    logic [7:0]                      s_red = '0;
    logic [7:0]                      s_green = '0;
    logic [7:0]                      s_blue = '0;
    logic [7:0]                      s_alpha = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [7:0]                      m_out_red;
    logic [7:0]                      m_out_green;
    logic [7:0]                      m_out_blue;
    logic [7:0]                      m_out_alpha;
    logic                            m_row_end;
    logic                            m_frame_end;
    int                              fail_count;
    int                              pending;
    int                              pixels_seen;
    int                              blocks_seen;

    recv_mode_t            recv_mode = RECV_OPEN;
    logic                  gaps_on = 1'b0;
    logic                  recv_phase = 1'b1;
    int unsigned           recv_run = 0;
    int unsigned           burst_left = 0;
    int unsigned           pixels_sent = 0;
    int unsigned           settings_used = 0;
    int unsigned           quiet_cycles = 0;

    rgba_box_downsample_2x2 #(.MAX_WIDTH(MAX_WIDTH)) dut (.*);

    box_downsample_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        case (recv_mode)
            RECV_OPEN: m_ready <= 1'b1;
            RECV_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
            default: begin
                if (recv_run == 0) begin
                    recv_run = $urandom_range(1, 30);
                    recv_phase = ~recv_phase;
                end
                recv_run--;
                m_ready <= recv_phase;
            end
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic rbd2_pkg::pix_vec_t rand_pixel();
        rbd2_pkg::pix_vec_t px;
        int unsigned        pick;
        pick = $urandom_range(0, 9);
        for (int c = 0; c < rbd2_pkg::NUM_CH; c++)
            px[c] = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom_range(0, 255));
        return px;
    endfunction

    task automatic write_reg(input rbd2_pkg::cfg_idx_t idx,
                             input logic [rbd2_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [rbd2_pkg::CFG_DATA_W-1:0] w,
                             input logic [rbd2_pkg::CFG_DATA_W-1:0] h);
        write_reg(rbd2_pkg::CFG_SRC_WIDTH, w);
        write_reg(rbd2_pkg::CFG_SRC_HEIGHT, h);
        settings_used++;
    endtask

    task automatic put_pixel(input logic sof, input rbd2_pkg::pix_vec_t px);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_start_of_frame <= sof;
        s_red <= px[0];
        s_green <= px[1];
        s_blue <= px[2];
        s_alpha <= px[3];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pixels(input int unsigned count, input logic first_sof);
        for (int unsigned i = 0; i < count; i++) put_pixel(first_sof && i == 0, rand_pixel());
    endtask

    // drop valid, wait for every due block, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_frame(input int unsigned w_eff, input int unsigned h_eff);
        int unsigned total, n, kind, room;
        if (pixels_sent >= TARGET_PIXELS) return;
        room = TARGET_PIXELS - pixels_sent;
        total = w_eff * h_eff;
        kind = $urandom_range(0, 9);
        if (total > FRAME_CAP || kind == 0)
            n = $urandom_range(1, (total > FRAME_CAP) ? FRAME_CAP : total);
        else
            n = total;
        if (n > room) n = room;
        send_pixels(n, 1'b1);
        pixels_sent += n;
        if (n == total && kind == 1) send_pixels($urandom_range(1, 6), 1'b0);
    endtask

    initial begin
        int unsigned                     pick, w_eff, h_eff;
        logic [rbd2_pkg::CFG_DATA_W-1:0] w_raw, h_raw;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // 1x1 at reset values, then a pixel past the end of the frame
        put_pixel(1'b1, {4{8'hFF}});
        put_pixel(1'b0, {4{8'h00}});
        settle();

        // zero width with bits above the register set, zero height
        configure(16'hE000, 16'h0000);
        put_pixel(1'b1, 32'h80FF_017F);
        settle();

        // 3x3: odd trailing column and row are dropped
        configure(16'h6003, 16'd3);
        for (int unsigned i = 0; i < 9; i++)
            put_pixel(i == 0, (i % 3 == 2 || i >= 6) ? 32'h0 : {4{8'hFF}});
        settle();

        // shrink the width in the middle of a row
        configure(16'd8, 16'd2);
        send_pixels(5, 1'b1);
        settle();
        write_reg(rbd2_pkg::CFG_SRC_WIDTH, 16'd4);
        send_pixels(5, 1'b0);
        settle();

        // width beyond the line store clamps to the maximum
        configure(16'h1FFF, 16'd1);
        send_pixels(4, 1'b1);
        settle();
        pixels_sent = 26;

        while (pixels_sent < TARGET_PIXELS) begin
            recv_mode = recv_mode_t'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 13) w_raw = 16'($urandom_range(1, 12));
            else if (pick < 17) w_raw = 16'($urandom_range(13, 80));
            else if (pick == 17) w_raw = '0;
            else w_raw = $urandom_range(0, 1) ? 16'd4096 : 16'($urandom_range(4095, 8191));
            if ($urandom_range(0, 3) == 0) w_raw[15:13] = 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 19);
            if (pick < 12) h_raw = 16'($urandom_range(1, 6));
            else if (pick < 17) h_raw = 16'($urandom_range(7, 20));
            else if (pick == 17) h_raw = '0;
            else if (pick == 18) h_raw = 16'hFFFF;
            else h_raw = 16'($urandom_range(21, 65535));
            w_eff = (w_raw[12:0] == 0) ? 1 : (w_raw[12:0] > MAX_WIDTH) ? MAX_WIDTH : w_raw[12:0];
            h_eff = (h_raw == 0) ? 1 : h_raw;
            configure(w_raw, h_raw);
            repeat ($urandom_range(1, 3)) run_frame(w_eff, h_eff);
            settle();
        end

        $display("covered %0d source pixels and %0d output blocks", pixels_seen, blocks_seen);
        $display("over %0d register settings with varied source gaps and sink stalls",
                 settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
